// ----- src/stq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stq_pkg
// Shared types, codes and the combine function for the segment tree block.
// ----------------------------------------------------------------------------
package stq_pkg;

   localparam int IDX_W    = 10;
   localparam int VAL_W    = 32;
   localparam int NODE_W   = IDX_W + 2;            // heap node address, 4 * leaves slots
   localparam int STACK_W  = 4;                    // traversal stack depth 16
   localparam int STACK_N  = 1 << STACK_W;

   // Operation codes.
   localparam logic [1:0] OP_FILL   = 2'd0;
   localparam logic [1:0] OP_UPDATE = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;

   // Combine modes.
   localparam logic [1:0] MODE_SUM = 2'd0;
   localparam logic [1:0] MODE_MIN = 2'd1;

   // Status codes.
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOT_INIT = 2'd1;
   localparam logic [1:0] ST_RANGE    = 2'd2;

   // Register indexes.
   localparam logic [1:0] REG_MODE     = 2'd0;
   localparam logic [1:0] REG_IDENTITY = 2'd1;
   localparam logic [1:0] REG_FIRST    = 2'd2;
   localparam logic [1:0] REG_LAST     = 2'd3;

   typedef struct packed {
      logic [1:0]       op;
      logic [IDX_W-1:0] first_index;
      logic [IDX_W-1:0] last_index;
      logic [VAL_W-1:0] value;
   } cmd_type;

   typedef struct packed {
      logic [1:0]       mode;
      logic [VAL_W-1:0] identity;
      logic [IDX_W-1:0] first;
      logic [IDX_W-1:0] last;
   } cfg_type;

   // Combine two node values under the selected mode; unused mode acts as maximum.
   function automatic logic [VAL_W-1:0] combine(input logic [1:0] mode,
                                                input logic [VAL_W-1:0] a,
                                                input logic [VAL_W-1:0] b);
      logic less;
      less = $signed(a) < $signed(b);
      case (mode)
         MODE_SUM: combine = a + b;
         MODE_MIN: combine = less ? a : b;
         default:  combine = less ? b : a;
      endcase
   endfunction

endpackage
`default_nettype wire

// ----- src/stq_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stq_engine
// Walks the tree depth first with a frame stack and reads, combines and
// writes back node values in a single-port synchronous node memory.
// ----------------------------------------------------------------------------
module stq_engine import stq_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire cmd_type          cmd,
   input  wire cfg_type          cfg,
   output logic                  done,
   output logic [VAL_W-1:0]      ret_value
);

   localparam logic [1:0] E_IDLE = 2'd0;
   localparam logic [1:0] E_RUN  = 2'd1;
   localparam logic [1:0] E_WAIT = 2'd2;
   localparam logic [1:0] E_DONE = 2'd3;

   // Node memory and its registered read port.
   logic [VAL_W-1:0] node_mem [0:(1 << NODE_W)-1];
   logic [VAL_W-1:0] rd_ff;

   logic [1:0]        state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [IDX_W-1:0]  s_ff, s_in, t_ff, t_in;
   logic [NODE_W-1:0] p_ff, p_in;
   logic [1:0]        stage_ff, stage_in;
   logic [VAL_W-1:0]  acc_ff, acc_in, ret_ff, ret_in;
   logic [STACK_W-1:0] sp_ff, sp_in;

   // Frame stack.
   logic [IDX_W-1:0]  stk_s   [0:STACK_N-1];
   logic [IDX_W-1:0]  stk_t   [0:STACK_N-1];
   logic [1:0]        stk_stg [0:STACK_N-1];
   logic [VAL_W-1:0]  stk_acc [0:STACK_N-1];

   logic              wr_en, rd_en, do_push, do_pop;
   logic [NODE_W-1:0] wr_addr, rd_addr;
   logic [VAL_W-1:0]  wr_data, push_acc, pop_val, comb_val;
   logic [1:0]        push_stage;
   logic [IDX_W:0]    sum_st;
   logic [IDX_W-1:0]  mid;
   logic              leaf, go_left, covered;
   logic [STACK_W-1:0] sp_dec;

   assign sum_st  = {1'b0, s_ff} + {1'b0, t_ff};
   assign mid     = sum_st[IDX_W:1];
   assign leaf    = (s_ff == t_ff);
   assign go_left = (cmd_ff.first_index <= mid);
   assign covered = (cmd_ff.first_index <= s_ff) && (t_ff <= cmd_ff.last_index);
   assign sp_dec  = sp_ff - 1'b1;

   // Traversal sequencer.
   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      s_in     = s_ff;
      t_in     = t_ff;
      p_in     = p_ff;
      stage_in = stage_ff;
      acc_in   = acc_ff;
      ret_in   = ret_ff;
      sp_in    = sp_ff;
      wr_en    = 1'b0;
      wr_addr  = p_ff;
      wr_data  = cmd_ff.value;
      rd_en    = 1'b0;
      rd_addr  = p_ff;
      do_push  = 1'b0;
      push_stage = 2'd0;
      push_acc = acc_ff;
      do_pop   = 1'b0;
      pop_val  = ret_ff;
      comb_val = '0;
      case (state_ff)
         E_IDLE: begin
            if (start) begin
               cmd_in   = cmd;
               s_in     = cfg.first;
               t_in     = cfg.last;
               p_in     = NODE_W'(1);
               stage_in = 2'd0;
               sp_in    = '0;
               state_in = E_RUN;
            end
         end
         E_RUN: begin
            case (cmd_ff.op)
               OP_FILL: begin
                  if (stage_ff == 2'd0) begin
                     if (leaf) begin
                        wr_en   = 1'b1;
                        do_pop  = 1'b1;
                        pop_val = cmd_ff.value;
                     end else begin
                        do_push    = 1'b1;
                        push_stage = 2'd1;
                        t_in       = mid;
                        p_in       = {p_ff[NODE_W-2:0], 1'b0};
                     end
                  end else if (stage_ff == 2'd1) begin
                     do_push    = 1'b1;
                     push_stage = 2'd2;
                     push_acc   = ret_ff;
                     s_in       = mid + 1'b1;
                     p_in       = {p_ff[NODE_W-2:0], 1'b1};
                  end else begin
                     comb_val = combine(cfg.mode, acc_ff, ret_ff);
                     wr_en    = 1'b1;
                     wr_data  = comb_val;
                     do_pop   = 1'b1;
                     pop_val  = comb_val;
                  end
               end
               OP_UPDATE: begin
                  if (stage_ff == 2'd0) begin
                     if (leaf) begin
                        wr_en   = 1'b1;
                        do_pop  = 1'b1;
                        pop_val = cmd_ff.value;
                     end else begin
                        do_push    = 1'b1;
                        push_stage = 2'd1;
                        if (go_left) begin
                           t_in = mid;
                           p_in = {p_ff[NODE_W-2:0], 1'b0};
                        end else begin
                           s_in = mid + 1'b1;
                           p_in = {p_ff[NODE_W-2:0], 1'b1};
                        end
                     end
                  end else begin
                     // Fetch the sibling of the child that just returned.
                     rd_en    = 1'b1;
                     rd_addr  = {p_ff[NODE_W-2:0], go_left};
                     acc_in   = ret_ff;
                     state_in = E_WAIT;
                  end
               end
               default: begin
                  if (stage_ff == 2'd0) begin
                     if (covered) begin
                        rd_en    = 1'b1;
                        state_in = E_WAIT;
                     end else if (go_left) begin
                        do_push    = 1'b1;
                        push_stage = 2'd1;
                        push_acc   = cfg.identity;
                        t_in       = mid;
                        p_in       = {p_ff[NODE_W-2:0], 1'b0};
                     end else begin
                        acc_in   = cfg.identity;
                        stage_in = 2'd1;
                     end
                  end else if (stage_ff == 2'd1) begin
                     comb_val = go_left ? combine(cfg.mode, ret_ff, acc_ff) : acc_ff;
                     if (cmd_ff.last_index > mid) begin
                        do_push    = 1'b1;
                        push_stage = 2'd2;
                        push_acc   = comb_val;
                        s_in       = mid + 1'b1;
                        p_in       = {p_ff[NODE_W-2:0], 1'b1};
                     end else begin
                        do_pop  = 1'b1;
                        pop_val = comb_val;
                     end
                  end else begin
                     do_pop  = 1'b1;
                     pop_val = combine(cfg.mode, ret_ff, acc_ff);
                  end
               end
            endcase
         end
         E_WAIT: begin
            do_pop = 1'b1;
            if (cmd_ff.op == OP_UPDATE) begin
               comb_val = combine(cfg.mode, acc_ff, rd_ff);
               wr_en    = 1'b1;
               wr_data  = comb_val;
               pop_val  = comb_val;
            end else begin
               pop_val = rd_ff;
            end
         end
         default: begin
            state_in = E_IDLE;
         end
      endcase

      // A push descends into the child chosen above with a fresh frame.
      if (do_push) begin
         stage_in = 2'd0;
         sp_in    = sp_ff + 1'b1;
      end

      // A pop hands the value up to the parent, or ends the walk at the root.
      if (do_pop) begin
         ret_in = pop_val;
         if (sp_ff == '0) begin
            state_in = E_DONE;
         end else begin
            sp_in    = sp_dec;
            s_in     = stk_s[sp_dec];
            t_in     = stk_t[sp_dec];
            stage_in = stk_stg[sp_dec];
            acc_in   = stk_acc[sp_dec];
            p_in     = {1'b0, p_ff[NODE_W-1:1]};
            state_in = E_RUN;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
         sp_ff    <= '0;
         stage_ff <= 2'd0;
      end else begin
         state_ff <= state_in;
         sp_ff    <= sp_in;
         stage_ff <= stage_in;
      end
   end

   // Frame and payload registers.
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      s_ff   <= s_in;
      t_ff   <= t_in;
      p_ff   <= p_in;
      acc_ff <= acc_in;
      ret_ff <= ret_in;
      if (do_push) begin
         stk_s[sp_ff]   <= s_ff;
         stk_t[sp_ff]   <= t_ff;
         stk_stg[sp_ff] <= push_stage;
         stk_acc[sp_ff] <= push_acc;
      end
   end

   // Node memory: one write or one read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= node_mem[rd_addr];
      end
   end

   assign done      = (state_ff == E_DONE);
   assign ret_value = ret_ff;

endmodule
`default_nettype wire

// ----- src/segment_tree_range_query_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// segment_tree_range_query_top
// Segment tree with fill, point update and range fold over a configured range.
// ----------------------------------------------------------------------------
//  Channel   Direction  Carries
//  req_*     in         operation, first_index, last_index, value
//  rsp_*     out        result_value, status
//  csr_*     in/out     combine_mode, identity_value, range_first, range_last
//
// One transaction at a time. A fill visits every node; an update walks one
// path from the root to a leaf and back; a query visits the nodes that its
// range needs, and each memory read waits on the registered RAM port.
// Reset clears control state; node memory is undefined until the first fill.
// The result register holds while rsp_tready is low; the next request is
// accepted once the previous result has moved into the result register.
// ----------------------------------------------------------------------------
module segment_tree_range_query_top import stq_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [1:0] operation, [11:2] first_index, [21:12] last_index, [53:22] value
   input  wire logic [55:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [31:0] result_value, [33:32] status
   output logic [39:0]      rsp_tdata,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam logic [1:0] T_IDLE = 2'd0;
   localparam logic [1:0] T_BUSY = 2'd1;
   localparam logic [1:0] T_OUT  = 2'd2;

   logic [1:0]       state_ff, state_in;
   cfg_type          cfg_ff, cfg_in;
   logic             init_ff, init_in;
   logic [1:0]       op_ff, op_in;
   logic [VAL_W-1:0] pend_val_ff, pend_val_in;
   logic [1:0]       pend_st_ff, pend_st_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0] rsp_val_ff, rsp_val_in;
   logic [1:0]       rsp_st_ff, rsp_st_in;
   logic             eng_start, eng_done, cfg_wr, req_acc;
   logic [VAL_W-1:0] eng_ret;
   cmd_type          cmd;
   logic             fi_bad, li_bad;

   assign cmd = '{op: req_tdata[1:0], first_index: req_tdata[11:2],
                  last_index: req_tdata[21:12], value: req_tdata[53:22]};

   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;
   assign req_tready = (state_ff == T_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign fi_bad     = (cmd.first_index < cfg_ff.first) || (cmd.first_index > cfg_ff.last);
   assign li_bad     = (cmd.last_index < cfg_ff.first) || (cmd.last_index > cfg_ff.last);

   // Register read mux.
   always_comb begin
      case (csr_paddr[3:2])
         REG_MODE:     csr_prdata = {30'd0, cfg_ff.mode};
         REG_IDENTITY: csr_prdata = cfg_ff.identity;
         REG_FIRST:    csr_prdata = {22'd0, cfg_ff.first};
         default:      csr_prdata = {22'd0, cfg_ff.last};
      endcase
   end

   // Request screening, engine launch and result hand-off.
   always_comb begin
      state_in     = state_ff;
      cfg_in       = cfg_ff;
      init_in      = init_ff;
      op_in        = op_ff;
      pend_val_in  = pend_val_ff;
      pend_st_in   = pend_st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_val_in   = rsp_val_ff;
      rsp_st_in    = rsp_st_ff;
      eng_start    = 1'b0;

      if (cfg_wr) begin
         case (csr_paddr[3:2])
            REG_MODE:     cfg_in.mode = csr_pwdata[1:0];
            REG_IDENTITY: cfg_in.identity = csr_pwdata;
            REG_FIRST: begin
               cfg_in.first = csr_pwdata[IDX_W-1:0];
               init_in      = 1'b0;
            end
            default: begin
               cfg_in.last = csr_pwdata[IDX_W-1:0];
               init_in     = 1'b0;
            end
         endcase
      end

      case (state_ff)
         T_IDLE: begin
            if (req_acc) begin
               op_in       = cmd.op;
               pend_val_in = '0;
               pend_st_in  = ST_OK;
               state_in    = T_OUT;
               case (cmd.op)
                  OP_FILL: begin
                     if (cfg_ff.first > cfg_ff.last) begin
                        pend_st_in = ST_RANGE;
                     end else begin
                        eng_start = 1'b1;
                        state_in  = T_BUSY;
                     end
                  end
                  OP_UPDATE: begin
                     if (!init_ff) begin
                        pend_st_in = ST_NOT_INIT;
                     end else if (fi_bad) begin
                        pend_st_in = ST_RANGE;
                     end else begin
                        eng_start = 1'b1;
                        state_in  = T_BUSY;
                     end
                  end
                  OP_QUERY: begin
                     if (!init_ff) begin
                        pend_st_in = ST_NOT_INIT;
                     end else if (fi_bad || li_bad) begin
                        pend_st_in = ST_RANGE;
                     end else if (cmd.first_index > cmd.last_index) begin
                        pend_val_in = cfg_ff.identity;
                     end else begin
                        eng_start = 1'b1;
                        state_in  = T_BUSY;
                     end
                  end
                  default: begin
                     pend_st_in = ST_OK;
                  end
               endcase
            end
         end
         T_BUSY: begin
            if (eng_done) begin
               pend_val_in = (op_ff == OP_QUERY) ? eng_ret : '0;
               pend_st_in  = ST_OK;
               if (op_ff == OP_FILL) begin
                  init_in = 1'b1;
               end
               state_in = T_OUT;
            end
         end
         T_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_val_in   = pend_val_ff;
               rsp_st_in    = pend_st_ff;
               state_in     = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   // Control and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         init_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cfg_ff       <= '{mode: MODE_SUM, identity: '0, first: '0, last: '1};
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      pend_val_ff <= pend_val_in;
      pend_st_ff  <= pend_st_in;
      rsp_val_ff  <= rsp_val_in;
      rsp_st_ff   <= rsp_st_in;
   end

   stq_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .start     (eng_start),
      .cmd       (cmd),
      .cfg       (cfg_ff),
      .done      (eng_done),
      .ret_value (eng_ret)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_st_ff, rsp_val_ff};

endmodule
`default_nettype wire

// ----- src/stq_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stq_checker
// Port-level checks on the result channel and the register port.
// ----------------------------------------------------------------------------
module stq_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata,
   input wire logic        csr_pready
);

   // A stalled result transaction stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // Only the three defined status codes appear.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[33:32] != 2'd3)
      else $error("undefined status code");

   // A failed request carries a zero result value.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[33:32] != 2'd0 |-> rsp_tdata[31:0] == 32'd0)
      else $error("nonzero value with error status");

   // No result is offered right after reset.
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

   // The register port never waits.
   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("register port stalled");

endmodule

bind segment_tree_range_query_top stq_checker u_stq_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_pready (csr_pready)
);
`default_nettype wire

// ----- test/segment_tree_range_query_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_tree_range_query_checker
// Watches the request, response and register channels of the segment tree.
// It keeps its own tree and register copy, computes the response for every
// accepted request and compares each accepted response in order.
// ----------------------------------------------------------------------------
module segment_tree_range_query_checker import stq_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   // [1:0] operation, [11:2] first_index, [21:12] last_index, [53:22] value
   input  wire logic [55:0] req_tdata,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // [31:0] result_value, [33:32] status
   input  wire logic [39:0] rsp_tdata,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output int               fail_count,
   output int               pending
);

   localparam int         SLOTS    = 4096;

   typedef struct packed {
      logic [VAL_W-1:0] result_value;
      logic [1:0]       status;
   } answer_type;

   logic [VAL_W-1:0] tree[SLOTS];
   logic             tree_ready;
   logic [1:0]       mode;
   logic [VAL_W-1:0] identity;
   logic [IDX_W-1:0] first;
   logic [IDX_W-1:0] last;
   answer_type       answers[$];

   // Combine under the current mode; the unused code behaves as maximum.
   function automatic logic [VAL_W-1:0] merge(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
      logic lt;
      lt = $signed(a) < $signed(b);
      if (mode == MODE_SUM) return a + b;
      if (mode == MODE_MIN) return lt ? a : b;
      return lt ? b : a;
   endfunction

   function automatic void fill_tree(int s, int t, int p, logic [VAL_W-1:0] v);
      int m;
      if (s == t) begin
         tree[p] = v;
         return;
      end
      m = (s + t) >> 1;
      fill_tree(s, m, 2 * p, v);
      fill_tree(m + 1, t, 2 * p + 1, v);
      tree[p] = merge(tree[2 * p], tree[2 * p + 1]);
   endfunction

   function automatic void set_leaf(int s, int t, int idx, logic [VAL_W-1:0] v, int p);
      int m;
      if (s == t) begin
         tree[p] = v;
         return;
      end
      m = (s + t) >> 1;
      if (idx <= m) set_leaf(s, m, idx, v, 2 * p);
      else          set_leaf(m + 1, t, idx, v, 2 * p + 1);
      tree[p] = merge(tree[2 * p], tree[2 * p + 1]);
   endfunction

   // Partly covered nodes start their fold from the identity value.
   function automatic logic [VAL_W-1:0] fold_range(int l, int r, int s, int t, int p);
      int               m;
      logic [VAL_W-1:0] acc;
      if (l <= s && t <= r) return tree[p];
      m   = (s + t) >> 1;
      acc = identity;
      if (l <= m) acc = merge(fold_range(l, r, s, m, 2 * p), acc);
      if (r > m)  acc = merge(fold_range(l, r, m + 1, t, 2 * p + 1), acc);
      return acc;
   endfunction

   function automatic answer_type predict_answer(cmd_type c);
      answer_type a;
      a = '{result_value: '0, status: ST_OK};
      case (c.op)
         OP_FILL: begin
            if (first > last) a.status = ST_RANGE;
            else begin
               fill_tree(first, last, 1, c.value);
               tree_ready = 1'b1;
            end
         end
         OP_UPDATE: begin
            if (!tree_ready) a.status = ST_NOT_INIT;
            else if (c.first_index < first || c.first_index > last) a.status = ST_RANGE;
            else set_leaf(first, last, c.first_index, c.value, 1);
         end
         OP_QUERY: begin
            if (!tree_ready) a.status = ST_NOT_INIT;
            else if (c.first_index < first || c.first_index > last ||
                     c.last_index < first || c.last_index > last) a.status = ST_RANGE;
            else if (c.first_index > c.last_index) a.result_value = identity;
            else a.result_value = fold_range(c.first_index, c.last_index, first, last, 1);
         end
         default: ;
      endcase
      return a;
   endfunction

   task automatic report(string what, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
      $display("%0t mismatch %s: expected %h, got %h", $realtime, what, want, got);
      fail_count++;
   endtask

   initial fail_count = 0;

   // Register writes, request predictions and response comparisons.
   always @(posedge clock) begin
      answer_type want;
      answer_type got;
      cmd_type    c;
      if (reset) begin
         tree_ready = 1'b0;
         mode       = MODE_SUM;
         identity   = '0;
         first      = '0;
         last       = '1;
         answers.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite) begin
            case (csr_paddr[3:2])
               REG_MODE:     mode = csr_pwdata[1:0];
               REG_IDENTITY: identity = csr_pwdata;
               REG_FIRST: begin
                  first      = csr_pwdata[IDX_W-1:0];
                  tree_ready = 1'b0;
               end
               default: begin
                  last       = csr_pwdata[IDX_W-1:0];
                  tree_ready = 1'b0;
               end
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = '{result_value: rsp_tdata[31:0], status: rsp_tdata[33:32]};
            if (answers.size() == 0) begin
               report("unexpected response transaction", '0, got.result_value);
            end else begin
               want = answers.pop_front();
               if (got.result_value !== want.result_value)
                  report("result_value", want.result_value, got.result_value);
               if (got.status !== want.status)
                  report("status", want.status, got.status);
            end
         end
         if (req_tvalid && req_tready) begin
            c = '{op: req_tdata[1:0], first_index: req_tdata[11:2],
                  last_index: req_tdata[21:12], value: req_tdata[53:22]};
            answers.push_back(predict_answer(c));
         end
      end
      pending = answers.size();
   end

endmodule

// ----- test/segment_tree_range_query_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_tree_range_query_top_tb
// Drives fills, point updates and range folds under several register
// settings, with bursty requests and a stalling response side; the checker
// predicts and compares every response.
// ----------------------------------------------------------------------------
module segment_tree_range_query_top_tb;
   import stq_pkg::*;

   localparam logic [1:0] OP_NONE  = 2'd3;
   localparam logic [1:0] MODE_MAX = 2'd2;
   localparam logic [1:0] MODE_ODD = 2'd3;
   localparam int         LIMIT    = 1500000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fail_count;
   int          pending;
   int          cycles;
   int          burst_left;
   logic        hold_off;
   int          cur_first;
   int          cur_last;

   segment_tree_range_query_top uut (.*);

   segment_tree_range_query_checker chk (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog on total run length.
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // Response side: random stall pattern, plus one long hold-off on request.
   initial begin
      int n;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_tready = 1'b0;
            for (n = 0; n < 400; n++) @(negedge clock);
            hold_off = 1'b0;
         end else if (cycles % 2000 < 700) begin
            rsp_tready = 1'b1;
         end else begin
            rsp_tready = ($urandom_range(0, 3) != 0);
         end
      end
   end

   task automatic csr_write(logic [1:0] idx, logic [31:0] data);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_pwrite  = 1'b1;
      csr_penable = 1'b0;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = data;
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   // Stop offering requests and wait until every expected response has come back.
   task automatic drain();
      int n;
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
      for (n = 0; n < 8; n++) @(negedge clock);
   endtask

   task automatic set_range(logic [1:0] mode_code, logic [31:0] ident, int lo, int hi);
      drain();
      csr_write(REG_MODE, {30'd0, mode_code});
      csr_write(REG_IDENTITY, ident);
      csr_write(REG_FIRST, lo);
      csr_write(REG_LAST, hi);
      cur_first = lo;
      cur_last  = hi;
   endtask

   // Offer one request transaction; the line stays high across a burst.
   task automatic send(logic [1:0] op, int fi, int li, logic [31:0] v);
      logic taken;
      int   n;
      if (!req_tvalid) @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = {2'b00, v, li[9:0], fi[9:0], op};
      do begin
         #0.2 taken = req_tready;
         @(posedge clock);
         @(negedge clock);
      end while (!taken);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid = 1'b0;
         burst_left = $urandom_range(0, 12);
         for (n = $urandom_range(0, 6); n > 0; n--) @(negedge clock);
      end
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom_range(0, 20) - 10;
         default: return $urandom;
      endcase
   endfunction

   function automatic int pick_index();
      if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1023);
      return $urandom_range(cur_first, cur_last);
   endfunction

   task automatic random_items(int count);
      int k;
      int r;
      int a;
      int b;
      for (k = 0; k < count; k++) begin
         r = $urandom_range(0, 99);
         a = pick_index();
         b = pick_index();
         if (r < 2) begin
            send(OP_FILL, $urandom_range(0, 1023), $urandom_range(0, 1023), pick_value());
         end else if (r < 45) begin
            send(OP_UPDATE, a, $urandom_range(0, 1023), pick_value());
         end else if (r < 96) begin
            if (a > b && $urandom_range(0, 4) != 0) send(OP_QUERY, b, a, $urandom);
            else send(OP_QUERY, a, b, $urandom);
         end else begin
            send(OP_NONE, $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom);
         end
      end
   endtask

   initial begin
      int p;
      int lo;
      int span;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      hold_off    = 1'b0;
      burst_left  = 0;
      cur_first   = 0;
      cur_last    = 1023;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: requests before any fill, then the full reset range.
      send(OP_UPDATE, 5, 0, 32'd1);
      send(OP_QUERY, 0, 1023, 32'd0);
      send(OP_NONE, 1023, 1023, 32'hffff_ffff);
      send(OP_FILL, 0, 0, 32'd3);
      send(OP_QUERY, 0, 1023, 32'd0);
      send(OP_UPDATE, 1023, 0, 32'h7fff_ffff);
      send(OP_UPDATE, 0, 0, 32'h8000_0000);
      send(OP_QUERY, 0, 1023, 32'd0);
      send(OP_QUERY, 1023, 1023, 32'd0);
      send(OP_QUERY, 700, 300, 32'd0);

      // Directed: narrow range at the top, minimum with an extreme identity.
      set_range(MODE_MIN, 32'h7fff_ffff, 1000, 1023);
      send(OP_QUERY, 1000, 1010, 32'd0);
      send(OP_FILL, 0, 0, 32'd9);
      send(OP_UPDATE, 999, 0, 32'd1);
      send(OP_QUERY, 1005, 1024 - 1, 32'd0);
      send(OP_QUERY, 1001, 1000, 32'd0);
      send(OP_QUERY, 990, 1010, 32'd0);
      send(OP_UPDATE, 1012, 0, 32'h8000_0000);
      send(OP_QUERY, 1000, 1023, 32'd0);

      // Directed: mode change keeps the tree, then a reversed range.
      drain();
      csr_write(REG_MODE, {30'd0, MODE_ODD});
      csr_write(REG_IDENTITY, 32'h8000_0000);
      send(OP_QUERY, 1003, 1017, 32'd0);
      set_range(MODE_MAX, 32'h0, 40, 30);
      send(OP_FILL, 0, 0, 32'd5);
      send(OP_QUERY, 35, 35, 32'd0);

      // Random phases under a set of register settings.
      for (p = 0; p < 9; p++) begin
         case (p)
            0: set_range(MODE_SUM, 32'h0, 0, 15);
            1: set_range(MODE_MIN, 32'h7fff_ffff, 100, 163);
            2: set_range(MODE_MAX, 32'h8000_0000, 960, 1023);
            3: set_range(MODE_ODD, 32'd5, 512, 512);
            4: set_range(MODE_SUM, $urandom, 0, 1023);
            default: begin
               lo   = $urandom_range(0, 1000);
               span = $urandom_range(1, 60);
               set_range(2'($urandom_range(0, 3)), $urandom, lo,
                         (lo + span > 1023) ? 1023 : lo + span);
            end
         endcase
         send(OP_FILL, 0, 0, pick_value());
         if (p == 4) begin
            random_items(15);
         end else begin
            random_items(50);
            // Switch the combine settings over the stored tree.
            drain();
            csr_write(REG_MODE, $urandom_range(0, 3));
            csr_write(REG_IDENTITY, $urandom);
            random_items(50);
         end
         if (p == 1) begin
            drain();
            hold_off = 1'b1;
            random_items(6);
         end
      end

      drain();
      repeat (50) @(posedge clock);
      if (fail_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule

// ----- sim.f -----
src/stq_pkg.sv
src/stq_engine.sv
src/segment_tree_range_query_top.sv
src/stq_checker.sv
test/segment_tree_range_query_checker.sv
test/segment_tree_range_query_top_tb.sv
